/* rtl/bfc_pkg.sv */
// Shared types and constants for the bisynch reply frame checker.
// Used by bfc_cfg, bfc_parser and the top level; no dependencies.
package bfc_pkg;

	// Framing characters
	localparam logic [7:0] CHR_STX = 8'h02;
	localparam logic [7:0] CHR_ETX = 8'h03;

	// Count limit where the frame byte counter saturates
	localparam logic [7:0] CNT_MAX = 8'hFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

	localparam logic [7:0] MAX_LEN_RST = 8'd99;

	// Frame status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOSTART  = 3'd1;
	localparam logic [2:0] ST_BADCMD   = 3'd2;
	localparam logic [2:0] ST_BADCHECK = 3'd3;
	localparam logic [2:0] ST_TOOLONG  = 3'd4;

	// Frame parser phase
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CMD1,
		PH_CMD2,
		PH_DATA,
		PH_BCC
	} phase_t;

	// Configuration register set
	typedef struct packed {
		logic [7:0] cmd_first;
		logic [7:0] cmd_second;
		logic [7:0] max_len;
	} cfg_t;

	// One result of the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_done;
		logic [2:0] frame_status;
	} res_t;

endpackage

/* rtl/bfc_cfg.sv */
// Configuration registers of the reply frame checker.
// Depends on bfc_pkg for register indexes and the cfg_t struct.
module bfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0] addr,
	input  logic [7:0]                    wdata,
	output bfc_pkg::cfg_t                 cfg
);
	import bfc_pkg::*;

	cfg_t cfg_q;

	// Register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_first  <= 8'd0;
			cfg_q.cmd_second <= 8'd0;
			cfg_q.max_len    <= MAX_LEN_RST;
		end else if (we) begin
			case (addr)
				CFG_CMD_FIRST:  cfg_q.cmd_first  <= wdata;
				CFG_CMD_SECOND: cfg_q.cmd_second <= wdata;
				CFG_MAX_LEN:    cfg_q.max_len    <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bfc_parser.sv */
// Frame parser: phase state machine, running XOR check, byte count and
// command compare. Depends on bfc_pkg for phase_t, cfg_t and res_t.
module bfc_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	input  bfc_pkg::cfg_t  cfg,
	output bfc_pkg::res_t  res
);
	import bfc_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] acc_q, acc_d;
	logic [7:0] cnt_q, cnt_d;
	logic       mis_q, mis_d;

	// Start of frame handling: STX in hunt restarts the running state
	logic       hunt;
	logic       no_start;
	phase_t     eff_phase;
	logic [7:0] acc_base;
	logic [7:0] cnt_base;
	logic       mis_base;
	logic [7:0] cnt_inc;
	logic       too_long;

	assign hunt      = (phase_q == PH_HUNT);
	assign no_start  = hunt && (rx_byte != CHR_STX);
	assign eff_phase = hunt ? PH_CMD1 : phase_q;
	assign acc_base  = hunt ? 8'd0 : acc_q;
	assign cnt_base  = hunt ? 8'd0 : cnt_q;
	assign mis_base  = hunt ? 1'b0 : mis_q;
	assign cnt_inc   = (cnt_base < CNT_MAX) ? cnt_base + 8'd1 : cnt_base;
	assign too_long  = (cnt_inc >= cfg.max_len);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (no_start) begin
			phase_d = PH_HUNT;
		end else if (too_long) begin
			phase_d = PH_HUNT;
		end else begin
			case (eff_phase)
				PH_CMD1: phase_d = (cnt_inc == 8'd1) ? PH_CMD1 : PH_CMD2;
				PH_CMD2: phase_d = PH_DATA;
				PH_DATA: phase_d = (rx_byte == CHR_ETX) ? PH_BCC : PH_DATA;
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Datapath updates and result
	always_comb begin
		acc_d            = acc_q;
		cnt_d            = cnt_q;
		mis_d            = mis_q;
		res              = '0;
		res.frame_status = ST_OK;
		if (no_start) begin
			res.valid        = 1'b1;
			res.frame_done   = 1'b1;
			res.frame_status = ST_NOSTART;
		end else if (too_long) begin
			acc_d            = 8'd0;
			cnt_d            = 8'd0;
			mis_d            = 1'b0;
			res.valid        = 1'b1;
			res.frame_done   = 1'b1;
			res.frame_status = ST_TOOLONG;
		end else begin
			cnt_d = cnt_inc;
			acc_d = acc_base;
			mis_d = mis_base;
			case (eff_phase)
				PH_CMD1: begin
					if (cnt_inc != 8'd1) begin
						acc_d = acc_base ^ rx_byte;
						mis_d = mis_base | (rx_byte != cfg.cmd_first);
					end
				end
				PH_CMD2: begin
					acc_d = acc_base ^ rx_byte;
					mis_d = mis_base | (rx_byte != cfg.cmd_second);
				end
				PH_DATA: begin
					acc_d = acc_base ^ rx_byte;
					if (rx_byte != CHR_ETX) begin
						res.valid      = 1'b1;
						res.data_byte  = rx_byte;
						res.data_valid = 1'b1;
					end
				end
				PH_BCC: begin
					acc_d          = 8'd0;
					cnt_d          = 8'd0;
					mis_d          = 1'b0;
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
					if (mis_base)
						res.frame_status = ST_BADCMD;
					else if (rx_byte != acc_base)
						res.frame_status = ST_BADCHECK;
				end
				default: begin
					acc_d = 8'd0;
					cnt_d = 8'd0;
					mis_d = 1'b0;
				end
			endcase
		end
	end

	// State registers, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			acc_q   <= 8'd0;
			cnt_q   <= 8'd0;
			mis_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			mis_q   <= mis_d;
		end
	end

	// Hunting means the running frame state has been cleared
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (cnt_q == 8'd0 && acc_q == 8'd0 && !mis_q))
		else $error("frame state not cleared in hunt");

	// Data or check phase is reached only after STX and two command bytes
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA || phase_q == PH_BCC) |-> (cnt_q >= 8'd3))
		else $error("data phase with short byte count");

	// A payload result never ends a frame
	a_data_res: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data_valid) |-> (!res.frame_done && res.frame_status == ST_OK))
		else $error("payload result marked as frame end");

endmodule

/* rtl/bisynch_reply_frame_checker_top.sv */
// Reply frame checker: a result reaches the output port through the input
// register, then the result register; one byte accepted per cycle with no
// bubbles while the output side keeps tready high. The input register and
// the result register each hold one transaction, so either side can stall
// alone.
// Asynchronous active-low reset returns to hunting for STX, clears the
// check state and loads register defaults (commands 0, length limit 99).
// Depends on bfc_pkg, bfc_cfg and bfc_parser.
module bisynch_reply_frame_checker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [7:0]                    cfg_wdata,
	// Received bytes
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
	// Results
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,   // [7:0] data_byte, [10:8] frame_status
	output logic                          m_axis_tuser,   // [0] data_valid
	output logic                          m_axis_tlast    // frame_done
);
	import bfc_pkg::*;

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       out_valid_s2;
	res_t       out_s2;

	bfc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// The parser consumes the held byte when the result register has room
	assign step          = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	bfc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step) begin
			out_valid_s2 <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid)
			out_s2 <= res;
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {5'd0, out_s2.frame_status, out_s2.data_byte};
	assign m_axis_tuser  = out_s2.data_valid;
	assign m_axis_tlast  = out_s2.frame_done;

	// A held result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !m_axis_tready) |-> !step)
		else $error("result register overwritten while stalled");

	// Each output transaction is either payload or a frame end, never both
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
		else $error("result neither payload nor frame end");

	// Input stage is freed whenever the parser consumes its byte
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> s_axis_tready)
		else $error("input stage blocked after consume");

endmodule
